/* design/tlac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed lid actuator controller package
// Shared types, register indexes, drive codes and arithmetic constants.
// ----------------------------------------------------------------------------
package tlac_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_PERCENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_LIMIT    = 3'd4;
    localparam int CFG_DATA_W = 12;

    // Register reset values.
    localparam logic [7:0]  TRAVEL_LIMIT_RST = 8'd14;
    localparam logic [7:0]  DWELL_LIMIT_RST  = 8'd12;
    localparam logic [9:0]  BIN_HEIGHT_RST   = 10'd60;
    localparam logic [6:0]  LOCK_PERCENT_RST = 7'd100;
    localparam logic [11:0] GAS_LIMIT_RST    = 12'd2000;

    // Motor drive codes.
    localparam logic [1:0] DRIVE_CLOSE   = 2'd0;
    localparam logic [1:0] DRIVE_OPEN    = 2'd1;
    localparam logic [1:0] DRIVE_STANDBY = 2'd2;

    // Echo time to tenths of an inch: (echo * 4425) >> 16.
    localparam logic [12:0] ECHO_SCALE   = 13'd4425;
    localparam int          PROD_W       = 28;
    localparam int          ECHO_SHIFT   = 16;
    localparam int          DIST_W       = PROD_W - ECHO_SHIFT;

    // Fill percent arithmetic.
    localparam int          NUM_W        = 17;
    localparam logic [6:0]  PCT_SCALE    = 7'd100;
    localparam logic [6:0]  FULL_PERCENT = 7'd100;
    localparam int          QUOT_W       = 7;
    localparam logic [7:0]  CNT_MAX      = 8'hFF;

    // Two quotient bits per step, one bit on the last step.
    localparam logic [1:0]  DIV_LAST_STEP = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NUM,
        ST_DIV,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request
        logic num;       // form the dividend and divisor
        logic div;       // one divide step
        logic div_last;  // the divide step is the single-bit last one
        logic fin;       // update lid state and load the result register
    } dp_cmd_t;

endpackage

/* design/tlac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed lid actuator controller sequencer
// Steps each request through dividend setup, the fill divide and the update.
// ----------------------------------------------------------------------------
module tlac_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output tlac_pkg::dp_cmd_t cmd
);
    import tlac_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_NUM:
            begin
                cmd.num   = 1'b1;
                step_next = 2'd0;
            end
            ST_DIV:
            begin
                cmd.div      = 1'b1;
                cmd.div_last = (step_reg == DIV_LAST_STEP);
                step_next    = step_reg + 2'd1;
            end
            ST_FIN:
            begin
                cmd.fin = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/tlac_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed lid actuator controller datapath
// Configuration registers, distance and fill arithmetic, lid state, results.
// ----------------------------------------------------------------------------
module tlac_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlac_pkg::dp_cmd_t                cmd,
    input  logic                             cfg_we,
    input  logic [tlac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlac_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             motion,
    input  logic [11:0]                      gas_level,
    input  logic [14:0]                      echo_us,
    output logic [1:0]                       lid_drive,
    output logic                             report_request,
    output logic [6:0]                       fill_percent,
    output logic [11:0]                      gas_report,
    output logic                             lid_open_flag
);
    import tlac_pkg::*;

    // Configuration.
    logic [7:0]  travel_limit_reg;
    logic [7:0]  dwell_limit_reg;
    logic [9:0]  bin_height_reg;
    logic [6:0]  lock_percent_reg;
    logic [11:0] gas_limit_reg;

    // Request and arithmetic.
    logic              motion_reg;
    logic [11:0]       gas_reg;
    logic [9:0]        dist_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dvs_reg;
    logic [QUOT_W-1:0] quot_reg;

    // Lid state.
    logic       open_reg;
    logic [7:0] travel_reg;
    logic [7:0] dwell_reg;
    logic       closed_rep_reg;
    logic       open_next;
    logic [7:0] travel_next;
    logic [7:0] dwell_next;
    logic       closed_rep_next;

    // Result register.
    logic [1:0]  drive_reg;
    logic        report_reg;
    logic [6:0]  fill_reg;
    logic [11:0] gas_out_reg;
    logic        open_flag_reg;
    logic [1:0]  drive_next;
    logic        report_next;

    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] dist_raw;
    logic [9:0]        dist_clamped;
    logic [9:0]        diff;
    logic [NUM_W-1:0]  num_val;
    logic              ge_hi;
    logic              ge_lo;
    logic [NUM_W-1:0]  rem_hi;
    logic [NUM_W-1:0]  rem_lo;
    logic [NUM_W-1:0]  dvs_half;
    logic [6:0]        fill_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_limit_reg <= TRAVEL_LIMIT_RST;
            dwell_limit_reg  <= DWELL_LIMIT_RST;
            bin_height_reg   <= BIN_HEIGHT_RST;
            lock_percent_reg <= LOCK_PERCENT_RST;
            gas_limit_reg    <= GAS_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRAVEL_LIMIT: travel_limit_reg <= cfg_data[7:0];
                REG_DWELL_LIMIT:  dwell_limit_reg  <= cfg_data[7:0];
                REG_BIN_HEIGHT:   bin_height_reg   <= cfg_data[9:0];
                REG_LOCK_PERCENT: lock_percent_reg <= cfg_data[6:0];
                REG_GAS_LIMIT:    gas_limit_reg    <= cfg_data[11:0];
                default:          ;
            endcase
        end
    end

    // Distance in tenths of an inch, clamped to the bin height.
    assign prod         = PROD_W'(echo_us) * PROD_W'(ECHO_SCALE);
    assign dist_raw     = prod[PROD_W-1:ECHO_SHIFT];
    assign dist_clamped = (dist_raw > DIST_W'(bin_height_reg)) ? bin_height_reg
                                                               : dist_raw[9:0];

    // Dividend with half the divisor added for round-to-nearest.
    assign diff    = bin_height_reg - dist_reg;
    assign num_val = NUM_W'(diff) * NUM_W'(PCT_SCALE) + NUM_W'(bin_height_reg >> 1);

    // Restoring divide, two quotient bits per step. The quotient never exceeds
    // 100, so seven bits starting at the divisor shifted by six cover it.
    assign dvs_half = dvs_reg >> 1;
    assign ge_hi    = (rem_reg >= dvs_reg);
    assign rem_hi   = ge_hi ? (rem_reg - dvs_reg) : rem_reg;
    assign ge_lo    = (rem_hi >= dvs_half);
    assign rem_lo   = ge_lo ? (rem_hi - dvs_half) : rem_hi;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            motion_reg <= motion;
            gas_reg    <= gas_level;
            dist_reg   <= dist_clamped;
        end
        if (cmd.num)
        begin
            rem_reg  <= num_val;
            dvs_reg  <= {1'b0, bin_height_reg, 6'b0};
            quot_reg <= '0;
        end
        else if (cmd.div)
        begin
            if (cmd.div_last)
            begin
                quot_reg <= {quot_reg[QUOT_W-2:0], ge_hi};
            end
            else
            begin
                rem_reg  <= rem_lo;
                dvs_reg  <= dvs_reg >> 2;
                quot_reg <= {quot_reg[QUOT_W-3:0], ge_hi, ge_lo};
            end
        end
    end

    // An empty bin height reads as a full bin.
    assign fill_val = (bin_height_reg == '0) ? FULL_PERCENT : quot_reg;

    always_comb
    begin
        open_next       = open_reg;
        travel_next     = travel_reg;
        dwell_next      = dwell_reg;
        closed_rep_next = closed_rep_reg;
        report_next     = 1'b0;
        drive_next      = DRIVE_CLOSE;

        if (motion_reg)
        begin
            if (!open_reg && (gas_reg < gas_limit_reg) && (fill_val < lock_percent_reg))
            begin
                open_next = 1'b1;
            end
            else
            begin
                report_next = 1'b1;
            end
        end
        else if (dwell_reg >= dwell_limit_reg)
        begin
            open_next  = 1'b0;
            dwell_next = '0;
        end

        if (open_next && (travel_reg < travel_limit_reg))
        begin
            drive_next = DRIVE_OPEN;
            if (travel_reg != CNT_MAX)
            begin
                travel_next = travel_reg + 8'd1;
            end
        end
        else if (open_next)
        begin
            drive_next = DRIVE_STANDBY;
            if (dwell_next != CNT_MAX)
            begin
                dwell_next = dwell_next + 8'd1;
            end
        end
        else
        begin
            drive_next = DRIVE_CLOSE;
            if (travel_reg != '0)
            begin
                travel_next     = travel_reg - 8'd1;
                closed_rep_next = 1'b0;
            end
            else if (!closed_rep_reg)
            begin
                closed_rep_next = 1'b1;
                report_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            travel_reg     <= '0;
            dwell_reg      <= '0;
            closed_rep_reg <= 1'b1;
        end
        else if (cmd.fin)
        begin
            open_reg       <= open_next;
            travel_reg     <= travel_next;
            dwell_reg      <= dwell_next;
            closed_rep_reg <= closed_rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            drive_reg     <= drive_next;
            report_reg    <= report_next;
            fill_reg      <= fill_val;
            gas_out_reg   <= gas_reg;
            open_flag_reg <= open_next;
        end
    end

    assign lid_drive      = drive_reg;
    assign report_request = report_reg;
    assign fill_percent   = fill_reg;
    assign gas_report     = gas_out_reg;
    assign lid_open_flag  = open_flag_reg;

endmodule

/* design/timed_lid_actuator_controller.sv */
`timescale 1ns / 1ps
// The sequencer steps each accepted request through the dividend setup,
// four restoring divide steps and the state update, and takes no new request
// until it is back in idle; a waiting result does not block the next request,
// only the update step waits for it.
// Reset (rst_n, asynchronous, active low) closes the lid, clears the counters
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// Timed lid actuator controller
// Turns half-second sensor ticks into lid motor commands and report requests.
// ----------------------------------------------------------------------------
module timed_lid_actuator_controller
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Tick request channel.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             motion,
    input  logic [11:0]                      gas_level,
    input  logic [14:0]                      echo_us,
    // Result channel.
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       lid_drive,
    output logic                             report_request,
    output logic [6:0]                       fill_percent,
    output logic [11:0]                      gas_report,
    output logic                             lid_open_flag,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlac_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tlac_pkg::*;

    dp_cmd_t cmd;

    // Configuration writes are always taken, unchecked; the user must send
    // them only while idle, so they never disturb a request in flight.
    assign cfg_ready = 1'b1;

    // The sequencer owns both handshakes; one command per cycle unless held.
    tlac_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the fill divider, the lid state
    // and the result register.
    tlac_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .motion         (motion),
        .gas_level      (gas_level),
        .echo_us        (echo_us),
        .lid_drive      (lid_drive),
        .report_request (report_request),
        .fill_percent   (fill_percent),
        .gas_report     (gas_report),
        .lid_open_flag  (lid_open_flag)
    );

`ifndef NO_ASSERTIONS
    // Once a request is taken the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a request was accepted");

    // Driving open only happens while the lid is meant to be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (lid_drive == DRIVE_OPEN)) |-> lid_open_flag)
        else $error("lid driven open while closed intent");

    // Driving shut only happens while the lid is meant to be closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (lid_drive == DRIVE_CLOSE)) |-> !lid_open_flag)
        else $error("lid driven shut while open intent");

    // The rounded fill percent never exceeds a full bin.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_percent <= FULL_PERCENT))
        else $error("fill percent above full");
`endif

endmodule
